FILE: hw/rtl/fir_pkg.sv
// fir_pkg: shared types and constants of the full convolution filter
// no dependencies; used by fir_cell and fir_full_convolution
package fir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 40;
    localparam int CFG_W    = 5;
    localparam int INDEX_W  = 4;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT
    } fir_state_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/fir_cell.sv
// fir_cell: one tap of the filter, holding a delay entry and a coefficient
// depends on fir_pkg; instantiated in a row by fir_full_convolution
module fir_cell
    import fir_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cell_ctrl_t                  ctrl,
    input  logic                        coef_we,
    input  logic signed [SAMPLE_W-1:0]  coef_in,
    input  logic                        active,
    input  logic signed [SAMPLE_W-1:0]  data_in,
    output logic signed [SAMPLE_W-1:0]  data_out,
    input  logic signed [ACC_W-1:0]     sum_in,
    output logic signed [ACC_W-1:0]     sum_out
);

    logic signed [SAMPLE_W-1:0] delay_reg;
    logic signed [SAMPLE_W-1:0] coef_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    sum_reg;
    logic signed [ACC_W-1:0]    sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            coef_reg  <= '0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                delay_reg <= '0;
            end
            else if (ctrl.shift)
            begin
                delay_reg <= data_in;
            end
            if (coef_we)
            begin
                coef_reg <= coef_in;
            end
        end
    end

    // inactive taps pass the partial sum unchanged
    always_comb
    begin
        if (active)
        begin
            sum_next = sum_in + ACC_W'(prod_reg);
        end
        else
        begin
            sum_next = sum_in;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(coef_reg) * PROD_W'(delay_reg);
        sum_reg  <= sum_next;
    end

    assign data_out = delay_reg;
    assign sum_out  = sum_reg;

endmodule

FILE: hw/rtl/fir_full_convolution.sv
// fir_full_convolution: top level, sequencer plus a row of TAPS cells
// depends on fir_pkg and fir_cell
//
// waves: each sample transaction starts a partial-sum wave that crosses the row of cells
//   one cell per cycle and is then loaded into the output register once that is free; the
//   input stays stalled until that result is loaded, so a new sample is accepted only after
//   the last one is done; a last sample with k active taps also keeps the input stalled for
//   k-1 flush results, and a load is accepted without stalling the input
// reset: delay line and coefficients clear to zero, tap_count resets to 1
module fir_full_convolution
    import fir_pkg::*;
#(
    parameter int TAPS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input item channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic [INDEX_W-1:0]          tap_index,
    input  logic signed [SAMPLE_W-1:0]  coef_value,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic                        last_sample,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [ACC_W-1:0]     conv_out,
    output logic                        last_out,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_W-1:0]            tap_count
);

    localparam int KW = $clog2(TAPS + 1);
    localparam int CW = $clog2(TAPS + 2);
    localparam logic [CW-1:0] WAVE_DONE = CW'(TAPS + 1);

    fir_state_t state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [KW-1:0]  rem_reg, rem_next;
    logic           last_reg, last_next;
    logic [CFG_W-1:0] tap_count_reg;

    logic              out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0] conv_reg;
    logic              last_out_reg;

    logic [KW-1:0]  k_eff;
    logic           in_acc;
    logic           sample_acc;
    logic           out_free;
    logic           wave_done;
    logic           load_out;
    cell_ctrl_t     ctrl;
    logic signed [SAMPLE_W-1:0] head_data;

    logic signed [SAMPLE_W-1:0] data_chain [TAPS+1];
    logic signed [ACC_W-1:0]    sum_chain  [TAPS+1];

    // configuration register, written only while idle with no input offered
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            tap_count_reg <= tap_count;
        end
    end

    // zero acts as one tap, above TAPS saturates
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(tap_count_reg) > TAPS)
        begin
            k_eff = KW'(TAPS);
        end
        else
        begin
            k_eff = KW'(tap_count_reg);
        end
    end

    // handshake terms
    assign in_stall   = (state_reg != S_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign sample_acc = in_acc && (op == OP_SAMPLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign wave_done  = (cnt_reg == WAVE_DONE);
    assign load_out   = (state_reg == S_WAIT) && wave_done && out_free;

    // sequencer: one result wave at a time, flush results follow a last sample
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        last_next  = last_reg;
        ctrl.shift = 1'b0;
        ctrl.clear = 1'b0;
        head_data  = sample;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_acc)
                begin
                    ctrl.shift = 1'b1;
                    cnt_next   = '0;
                    last_next  = last_sample;
                    rem_next   = last_sample ? (k_eff - KW'(1)) : '0;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!wave_done)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (out_free)
                begin
                    if (rem_reg != '0)
                    begin
                        // flush step: shift a zero in and start a new wave
                        ctrl.shift = 1'b1;
                        head_data  = '0;
                        rem_next   = rem_reg - KW'(1);
                        cnt_next   = '0;
                    end
                    else
                    begin
                        ctrl.clear = last_reg;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            last_reg  <= last_next;
        end
    end

    // output register decouples the result side from the input side
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            conv_reg     <= sum_chain[TAPS];
            last_out_reg <= last_reg && (rem_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign conv_out  = conv_reg;
    assign last_out  = last_out_reg;

    // row of cells: samples move right on a shift, partial sums move right
    // every cycle and pick up each active tap's product
    assign data_chain[0] = head_data;
    assign sum_chain[0]  = '0;

    for (genvar i = 0; i < TAPS; i++)
    begin : g_cell
        logic coef_we;
        logic active;

        assign coef_we = in_acc && (op == OP_LOAD) && (int'(tap_index) == i);
        assign active  = (k_eff > KW'(i));

        fir_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .coef_we  (coef_we),
            .coef_in  (coef_value),
            .active   (active),
            .data_in  (data_chain[i]),
            .data_out (data_chain[i+1]),
            .sum_in   (sum_chain[i]),
            .sum_out  (sum_chain[i+1])
        );
    end

    // a sample transaction starts a fresh wave
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc |=> (state_reg == S_WAIT) && (cnt_reg == '0))
        else $error("sample transaction did not start a wave");

    // the wave counter advances by one until the sum reaches the row end
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) && !wave_done |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("wave counter skipped");

    // the final result of a transaction returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (rem_reg == '0) |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle");

    // flush count never exceeds the active tap count
    assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < k_eff || rem_reg == '0)
        else $error("flush count out of range");

    // a result is loaded only when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_valid_reg || !out_stall)
        else $error("result overwrote a pending transaction");

endmodule
